>>> src/rdce_pkg.sv
// ----------------------------------------------------------------------------
// rdce_pkg - shared types and constants of the run-length encoder
// Run cap, widths, the decimal digit table and the run job type.
// ----------------------------------------------------------------------------
package rdce_pkg;

  // Longest run held before it is closed and emitted
  localparam int MAX_RUN = 65535;

  // Run count width: enough to hold MAX_RUN itself
  localparam int CNT_W = $clog2(MAX_RUN + 1);

  // Number of decimal digits of the largest count
  function automatic int num_digits(input longint v);
    longint p;
    int     n;
    p = 10;
    n = 1;
    while (p <= v) begin
      p = p * 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int NDIG  = num_digits(MAX_RUN);
  localparam int POS_W = (NDIG > 1) ? $clog2(NDIG) : 1;

  // d * 10^k fits in four bits more than the count
  localparam int PROD_W = CNT_W + 4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  typedef logic [9:0][PROD_W-1:0] mult_row_t;
  typedef mult_row_t [NDIG-1:0]   mult_tab_t;

  // Entry [k][d] holds d * 10^k
  function automatic mult_tab_t mult_table();
    mult_tab_t t;
    longint    p;
    p = 1;
    for (int k = 0; k < NDIG; k++) begin
      for (int d = 0; d < 10; d++) begin
        t[k][d] = PROD_W'(p * d);
      end
      p = p * 10;
    end
    return t;
  endfunction

  localparam mult_tab_t MULT_TAB = mult_table();

  // One finished run on its way to the digit emitter
  typedef struct packed {
    logic [7:0]       sym;
    logic [CNT_W-1:0] count;
    logic             item_done;
    logic             string_done;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIGITS,
    B_SYMBOL
  } back_state_t;

endpackage

>>> src/rle_decimal_count_encoder_top.sv
// ----------------------------------------------------------------------------
// rle_decimal_count_encoder_top - run-length encoder with decimal counts
// Encodes a byte string as runs: count in ASCII decimal, then the symbol.
//
//   channel | handshake        | fields
//   --------+------------------+------------------------------------------
//   input   | push / full      | in_byte[7:0], string_end
//   result  | empty / pop      | out_byte[7:0], is_symbol, item_done,
//           |                  | string_done
//
// A byte that closes no run is taken every cycle. A byte that closes runs
// holds full while the tracker hands its jobs to the queue. The emitter
// writes one result per cycle while its result slot is free or popped: a run
// gives its count digits, then its symbol, after a load when it was idle.
// Reset clears the open run, the job queue and the output valid flag.
// A stalled result side fills the two-entry job queue and then holds full.
// ----------------------------------------------------------------------------
module rle_decimal_count_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       is_symbol,
  output logic       item_done,
  output logic       string_done
);

  logic           job_valid;
  rdce_pkg::job_t job;
  logic           job_full;
  logic           q_valid;
  rdce_pkg::job_t q_job;
  logic           q_pop;
  logic           out_valid;

  rdce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .string_end (string_end),
    .job_valid  (job_valid),
    .job        (job),
    .job_full   (job_full)
  );

  rdce_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_valid),
    .wr_job   (job),
    .q_full   (job_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  rdce_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .pop         (pop),
    .out_byte    (out_byte),
    .is_symbol   (is_symbol),
    .item_done   (item_done),
    .string_done (string_done)
  );

  assign empty = !out_valid;

endmodule

>>> src/rdce_front.sv
// ----------------------------------------------------------------------------
// rdce_front - run tracker
// Takes string bytes, tracks the open run and turns each closed run into a
// job for the digit emitter. One byte can close up to two runs.
// ----------------------------------------------------------------------------
module rdce_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte,
  input  logic               string_end,
  output logic               job_valid,
  output rdce_pkg::job_t     job,
  input  logic               job_full
);

  logic [7:0]                run_symbol;
  logic [rdce_pkg::CNT_W-1:0] run_count;
  logic                      run_open;

  logic                      pend_a_valid;
  logic                      pend_b_valid;
  rdce_pkg::job_t            pend_a;
  rdce_pkg::job_t            pend_b;

  logic                      accept;
  logic                      same;
  logic                      a_valid;
  logic                      b_valid;
  logic                      cap;
  logic [rdce_pkg::CNT_W-1:0] count_next;
  rdce_pkg::job_t            job_a_next;
  rdce_pkg::job_t            job_b_next;

  assign full   = pend_a_valid || pend_b_valid;
  assign accept = push && !full;

  always_comb begin
    same       = run_open && (in_byte == run_symbol);
    a_valid    = run_open && !same;
    count_next = same ? run_count + 1'b1 : rdce_pkg::CNT_W'(1);
    cap        = count_next >= rdce_pkg::CNT_W'(rdce_pkg::MAX_RUN);
    b_valid    = cap || string_end;

    job_a_next.sym         = run_symbol;
    job_a_next.count       = run_count;
    job_a_next.item_done   = !b_valid;
    job_a_next.string_done = string_end && !b_valid;

    job_b_next.sym         = in_byte;
    job_b_next.count       = count_next;
    job_b_next.item_done   = 1'b1;
    job_b_next.string_done = string_end;
  end

  assign job_valid = pend_a_valid || pend_b_valid;
  assign job       = pend_a_valid ? pend_a : pend_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol   <= '0;
      run_count    <= '0;
      run_open     <= 1'b0;
      pend_a_valid <= 1'b0;
      pend_b_valid <= 1'b0;
    end else begin
      if (accept) begin
        run_symbol   <= in_byte;
        run_count    <= count_next;
        run_open     <= !b_valid;
        pend_a_valid <= a_valid;
        pend_b_valid <= b_valid;
        pend_a       <= job_a_next;
        pend_b       <= job_b_next;
      end else if (!job_full) begin
        // drain the older run first
        if (pend_a_valid) begin
          pend_a_valid <= 1'b0;
        end else if (pend_b_valid) begin
          pend_b_valid <= 1'b0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_string_done_ends_item: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.string_done |-> job.item_done)
    else $error("string_done on a job that does not close its item");
`endif

endmodule

>>> src/rdce_jobq.sv
// ----------------------------------------------------------------------------
// rdce_jobq - run job queue
// Short first-in first-out queue of closed runs between tracker and emitter.
// ----------------------------------------------------------------------------
module rdce_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  rdce_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd_en,
  output logic           rd_valid,
  output rdce_pkg::job_t rd_job
);

  rdce_pkg::job_t                  entries [rdce_pkg::JOBQ_DEPTH];
  logic [rdce_pkg::JOBQ_PTR_W-1:0] wr_ptr;
  logic [rdce_pkg::JOBQ_PTR_W-1:0] rd_ptr;
  logic [rdce_pkg::JOBQ_CNT_W-1:0] cnt;
  logic                            do_wr;
  logic                            do_rd;

  assign q_full   = cnt == rdce_pkg::JOBQ_CNT_W'(rdce_pkg::JOBQ_DEPTH);
  assign rd_valid = cnt != '0;
  assign rd_job   = entries[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= rdce_pkg::JOBQ_CNT_W'(rdce_pkg::JOBQ_DEPTH))
    else $error("job queue count beyond depth");
`endif

endmodule

>>> src/rdce_back.sv
// ----------------------------------------------------------------------------
// rdce_back - digit emitter
// Takes one run job at a time, writes its count as decimal digits, most
// significant first, then the symbol, one byte per cycle into the output
// register while that register is free or being popped.
// ----------------------------------------------------------------------------
module rdce_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  rdce_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           is_symbol,
  output logic           item_done,
  output logic           string_done
);

  rdce_pkg::back_state_t        state;
  rdce_pkg::back_state_t        state_next;

  logic [rdce_pkg::CNT_W-1:0]   rem;
  logic [rdce_pkg::POS_W-1:0]   pos;
  logic [7:0]                   sym;
  logic                         job_item_done;
  logic                         job_string_done;

  logic                         slot_free;
  logic                         load;
  logic                         emit_digit;
  logic                         emit_sym;
  logic [rdce_pkg::PROD_W-1:0]  rem_ext;
  logic [rdce_pkg::PROD_W-1:0]  load_ext;
  logic [3:0]                   dig;
  logic [rdce_pkg::CNT_W-1:0]   rem_next;
  logic [rdce_pkg::POS_W-1:0]   start_pos;

  assign slot_free = !out_valid || pop;
  assign rem_ext   = rdce_pkg::PROD_W'(rem);
  assign load_ext  = rdce_pkg::PROD_W'(q_job.count);

  // position of the leading digit
  always_comb begin
    start_pos = '0;
    for (int k = 1; k < rdce_pkg::NDIG; k++) begin
      if (load_ext >= rdce_pkg::MULT_TAB[k][1]) begin
        start_pos = rdce_pkg::POS_W'(k);
      end
    end
  end

  // digit at the current position: largest d with d * 10^pos <= rem
  always_comb begin
    dig = '0;
    for (int d = 1; d < 10; d++) begin
      if (rem_ext >= rdce_pkg::MULT_TAB[pos][d]) begin
        dig = 4'(d);
      end
    end
    rem_next = rdce_pkg::CNT_W'(rem_ext - rdce_pkg::MULT_TAB[pos][dig]);
  end

  always_comb begin
    state_next = state;
    case (state)
      rdce_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = rdce_pkg::B_DIGITS;
        end
      end
      rdce_pkg::B_DIGITS: begin
        if (slot_free && (pos == '0)) begin
          state_next = rdce_pkg::B_SYMBOL;
        end
      end
      rdce_pkg::B_SYMBOL: begin
        if (slot_free) begin
          state_next = q_valid ? rdce_pkg::B_DIGITS : rdce_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = rdce_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    load       = 1'b0;
    emit_digit = 1'b0;
    emit_sym   = 1'b0;
    case (state)
      rdce_pkg::B_IDLE: begin
        load = q_valid;
      end
      rdce_pkg::B_DIGITS: begin
        emit_digit = slot_free;
      end
      rdce_pkg::B_SYMBOL: begin
        emit_sym = slot_free;
        load     = slot_free && q_valid;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdce_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_digit || emit_sym) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem             <= q_job.count;
      pos             <= start_pos;
      sym             <= q_job.sym;
      job_item_done   <= q_job.item_done;
      job_string_done <= q_job.string_done;
    end else if (emit_digit) begin
      rem <= rem_next;
      if (pos != '0) begin
        pos <= pos - 1'b1;
      end
    end

    if (emit_digit) begin
      out_byte    <= rdce_pkg::ASCII_ZERO + {4'b0000, dig};
      is_symbol   <= 1'b0;
      item_done   <= 1'b0;
      string_done <= 1'b0;
    end else if (emit_sym) begin
      out_byte    <= sym;
      is_symbol   <= 1'b1;
      item_done   <= job_item_done;
      string_done <= job_string_done;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_next_power: assert property (@(posedge clk) disable iff (rst)
    state == rdce_pkg::B_DIGITS |->
      ({1'b0, rem_ext} < ({1'b0, rdce_pkg::MULT_TAB[pos][9]} +
                          {1'b0, rdce_pkg::MULT_TAB[pos][1]})))
    else $error("remainder too large for digit position");

  a_rem_spent: assert property (@(posedge clk) disable iff (rst)
    state == rdce_pkg::B_SYMBOL |-> rem == '0)
    else $error("count not fully emitted before symbol");

  a_digit_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_symbol |->
      (out_byte >= rdce_pkg::ASCII_ZERO) && (out_byte <= rdce_pkg::ASCII_ZERO + 8'd9))
    else $error("count result is not a decimal digit");
`endif

endmodule

>>> sim/tb_rle_decimal_count_encoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_decimal_count_encoder_top - testbench of the decimal run-length encoder
// Feeds byte strings through the input queue interface and predicts every
// encoded byte (decimal count digits, then the symbol) with its end markers.
// Each popped result is compared field by field with the oldest prediction.
// The run has three phases with different idle rates on both sides, and it
// includes runs with counts of one, two and three digits.
// ----------------------------------------------------------------------------
module tb_rle_decimal_count_encoder_top;

  localparam logic [7:0] DIGIT_BASE  = 8'h30;
  localparam int         STALL_LIMIT = 5000;
  localparam int         TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } str_byte_t;

  typedef struct packed {
    logic [7:0] code;
    logic       symbol;
    logic       item_last;
    logic       string_last;
  } enc_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       string_end = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       is_symbol;
  logic       item_done;
  logic       string_done;

  wire in_fire  = push && !full;
  wire out_fire = pop && !empty;

  // Bytes waiting to be pushed, and encoded bytes still to be popped
  str_byte_t pending_bytes[$];
  enc_out_t  encoded_q[$];
  enc_out_t  step_out[$];
  enc_out_t  exp_r;

  // Encoder state as the block should hold it
  logic [7:0]                 cur_sym  = 8'h00;
  logic [rdce_pkg::CNT_W-1:0] cur_len  = '0;
  logic                       run_live = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_cnt      = 0;
  int bytes_in      = 0;
  int results_seen  = 0;
  int strings_sent  = 0;
  int quiet_cycles  = 0;

  rle_decimal_count_encoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .string_end  (string_end),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .is_symbol   (is_symbol),
    .item_done   (item_done),
    .string_done (string_done)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Append one predicted byte to the results of the current step
  task automatic add_expected(input logic [7:0] code, input logic symbol);
    enc_out_t e;
    e.code        = code;
    e.symbol      = symbol;
    e.item_last   = 1'b0;
    e.string_last = 1'b0;
    step_out.insert(step_out.size(), e);
  endtask

  // Close the open run: count digits, most significant first, then the symbol
  task automatic close_run();
    logic [7:0]                 digs[$];
    logic [rdce_pkg::CNT_W-1:0] c;
    c = cur_len;
    do begin
      digs.push_front(DIGIT_BASE + 8'(c % 10));
      c = rdce_pkg::CNT_W'(c / 10);
    end while (c != 0);
    foreach (digs[i]) begin
      add_expected(digs[i], 1'b0);
    end
    add_expected(cur_sym, 1'b1);
    run_live = 1'b0;
  endtask

  task automatic rle_encode_step(input logic [7:0] b, input logic e);
    step_out.delete();
    if (!run_live) begin
      cur_sym  = b;
      cur_len  = rdce_pkg::CNT_W'(1);
      run_live = 1'b1;
    end else if (b == cur_sym) begin
      cur_len = cur_len + 1'b1;
    end else begin
      close_run();
      cur_sym  = b;
      cur_len  = rdce_pkg::CNT_W'(1);
      run_live = 1'b1;
    end
    if (run_live && cur_len >= rdce_pkg::MAX_RUN) close_run();
    if (e && run_live) close_run();
    if (step_out.size() > 0) begin
      step_out[step_out.size()-1].item_last = 1'b1;
      if (e) step_out[step_out.size()-1].string_last = 1'b1;
    end
    foreach (step_out[i]) encoded_q.insert(encoded_q.size(), step_out[i]);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      fail_cnt++;
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endtask

  task automatic add_run(input logic [7:0] sym, input int len, input bit closes);
    str_byte_t sb;
    for (int k = 0; k < len; k++) begin
      sb.data = sym;
      sb.last = closes && (k == len - 1);
      pending_bytes.insert(pending_bytes.size(), sb);
    end
    if (closes) strings_sent++;
  endtask

  // Strings of a few runs; half of them draw from a four-letter alphabet so
  // that neighbouring runs often merge
  task automatic add_random_strings(input int n);
    int         added;
    int         runs;
    int         len;
    int         p;
    bit         narrow;
    logic [7:0] sym;
    added = 0;
    while (added < n) begin
      runs   = $urandom_range(6, 1);
      narrow = 1'($urandom_range(1, 0));
      for (int r = 0; r < runs; r++) begin
        sym = narrow ? 8'(8'h41 + $urandom_range(3, 0)) : 8'($urandom_range(255, 0));
        p   = $urandom_range(99, 0);
        if (p < 70) len = $urandom_range(3, 1);
        else if (p < 95) len = $urandom_range(15, 4);
        else len = $urandom_range(120, 16);
        add_run(sym, len, r == runs - 1);
        added += len;
      end
    end
  endtask

  // Hold until every byte is pushed and every prediction has been popped
  task automatic drain();
    @(negedge clk);
    while (pending_bytes.size() != 0 || push || encoded_q.size() != 0) @(negedge clk);
  endtask

  // Driver: hold the transaction until taken, then maybe idle
  always @(posedge clk) begin
    if (rst) begin
      push       <= 1'b0;
      in_byte    <= 8'h00;
      string_end <= 1'b0;
    end else begin
      if (in_fire) begin
        bytes_in++;
        rle_encode_step(in_byte, string_end);
      end
      if (!push || !full) begin
        if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          push       <= 1'b1;
          in_byte    <= pending_bytes[0].data;
          string_end <= pending_bytes[0].last;
          void'(pending_bytes.pop_front());
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (out_fire) begin
        results_seen++;
        if (encoded_q.size() == 0) begin
          fail_cnt++;
          $error("unexpected result: out_byte %0h is_symbol %0b", out_byte, is_symbol);
        end else begin
          exp_r = encoded_q.pop_front();
          check_field("out_byte", exp_r.code, out_byte);
          check_field("is_symbol", exp_r.symbol, is_symbol);
          check_field("item_done", exp_r.item_last, item_done);
          check_field("string_done", exp_r.string_last, string_done);
        end
      end
      pop <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 34;
    recv_idle_pct = 85;
    add_run(8'h00, 1, 1'b1);
    add_run(8'hFF, 1, 1'b1);
    // new symbol on the final byte closes two runs in one transaction
    add_run(8'h41, 2, 1'b0);
    add_run(8'h42, 1, 1'b1);
    add_run(8'h78, 10, 1'b1);
    add_run(8'h55, 1, 1'b0);
    add_run(8'hAA, 1, 1'b0);
    add_run(8'h55, 1, 1'b1);
    add_run(8'h63, 3, 1'b1);
    // symbol that looks like a count digit
    add_run(8'h31, 2, 1'b1);
    add_random_strings(60);
    drain();

    send_idle_pct = 85;
    recv_idle_pct = 34;
    add_random_strings(80);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_strings(80);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (encoded_q.size() != 0) begin
      fail_cnt++;
      $error("%0d predicted results never arrived", encoded_q.size());
    end

    $display("Encoded %0d strings (%0d bytes in, %0d bytes out) over three idle profiles,",
             strings_sent, bytes_in, results_seen);
    $display("with single-byte strings, two runs closed at once and multi-digit counts.");
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
